// ===== hw/rtl/gdw_pkg.sv =====
// Shared types and constants for the grid line cell walker.
// No dependencies; imported by gdw_step and grid_line_cell_walker.
package gdw_pkg;

    localparam int MAX_DIM   = 64;
    localparam int DIM_W     = $clog2(MAX_DIM + 1);        // grid register width
    localparam int DELTA_W   = $clog2(MAX_DIM);            // |delta| and coordinate in grid
    localparam int ERR_W     = DELTA_W + 1;                // error term plus minor delta
    localparam int STEP_W    = DIM_W + 1;                  // signed step, +-width
    localparam int OFF_W     = $clog2(MAX_DIM * MAX_DIM);  // cell offset
    localparam int OFFS_W    = OFF_W + 1;                  // signed running offset
    localparam int COORD_W   = 8;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SETUP  = 5'b00010,
        S_ENDOFF = 5'b00100,
        S_WALK   = 5'b01000,
        S_LAST   = 5'b10000
    } t_state;

    // Line parameters fixed for the whole walk
    typedef struct packed {
        logic        [DELTA_W-1:0] major;
        logic        [DELTA_W-1:0] minor;
        logic signed [STEP_W-1:0]  step_a;
        logic signed [STEP_W-1:0]  step_b;
    } t_line;

    // Walk position, advanced one cell per step
    typedef struct packed {
        logic signed [OFFS_W-1:0] offset;
        logic        [ERR_W-1:0]  err;
    } t_walk;

endpackage

// ===== hw/rtl/gdw_step.sv =====
// Bresenham step unit: advance the walk position by one cell.
// Depends on gdw_pkg.
module gdw_step
    import gdw_pkg::*;
(
    input  t_line i_line,
    input  t_walk i_cur,
    output t_walk o_nxt
);

    logic [ERR_W-1:0]         err_sum;
    logic                     take_b;
    logic signed [OFFS_W-1:0] step_a_x;
    logic signed [OFFS_W-1:0] step_b_x;

    always_comb begin
        // err stays below major, so err plus minor fits ERR_W bits
        err_sum  = i_cur.err + {1'b0, i_line.minor};
        take_b   = (err_sum >= {1'b0, i_line.major});
        step_a_x = {{(OFFS_W-STEP_W){i_line.step_a[STEP_W-1]}}, i_line.step_a};
        step_b_x = {{(OFFS_W-STEP_W){i_line.step_b[STEP_W-1]}}, i_line.step_b};
        o_nxt.err    = take_b ? (err_sum - {1'b0, i_line.major}) : err_sum;
        o_nxt.offset = i_cur.offset + step_a_x + (take_b ? step_b_x : '0);
    end

endmodule

// ===== hw/rtl/grid_line_cell_walker.sv =====
// Grid line cell walker: walks a line between two grid cells on linear offsets.
// Depends on gdw_pkg and gdw_step.
//
// Sequence: S_SETUP and S_ENDOFF, then S_WALK emits one word per walk cycle
// from the step unit while the output is free, then S_LAST the end word; a
// request off the grid returns from S_SETUP to idle, where the next is taken.
// Reset (synchronous, active low): sequencer idle, output empty, width and
// height back to 64.
module grid_line_cell_walker
    import gdw_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // line request channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [COORD_W-1:0]  i_start_x,
    input  logic signed [COORD_W-1:0]  i_start_y,
    input  logic signed [COORD_W-1:0]  i_end_x,
    input  logic signed [COORD_W-1:0]  i_end_y,
    // cell result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [OFF_W-1:0]           o_cell_offset,
    output logic                       o_mark,
    output logic                       o_last,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [DIM_W-1:0]           i_cfg_data
);

    // Coordinate lies in [0, dim)
    function automatic logic in_range(input logic signed [COORD_W-1:0] c,
                                      input logic [DIM_W-1:0] dim);
        logic ok;
        ok = !c[COORD_W-1] && (c[COORD_W-2:0] < dim);
        return ok;
    endfunction

    t_state r_state, n_state;

    logic [DIM_W-1:0] r_grid_width;
    logic [DIM_W-1:0] r_grid_height;

    // captured request
    logic signed [COORD_W-1:0] r_x0, r_y0, r_x1, r_y1;

    t_line              r_line;
    t_walk              r_walk;
    logic [DELTA_W-1:0] r_cnt;
    logic [OFF_W-1:0]   r_end_off;

    // output register
    logic             r_out_valid;
    logic [OFF_W-1:0] r_out_off;
    logic             r_out_mark;
    logic             r_out_last;

    logic [DIM_W-1:0]           w_eff, h_eff;
    logic                       ends_ok;
    logic signed [COORD_W:0]    dx, dy;
    logic [DELTA_W-1:0]         adx, ady;
    logic signed [STEP_W-1:0]   sdx, sdy;
    t_line                      line_c;
    logic [DELTA_W-1:0]         cnt_c;
    logic signed [COORD_W-1:0]  mul_x, mul_y;
    logic [OFF_W:0]             mul_sum;
    logic [OFF_W-1:0]           mul_off;
    t_walk                      walk_nxt;
    logic                       out_free;
    logic                       accept_in;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept_in   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_cell_offset = r_out_off;
    assign o_mark        = r_out_mark;
    assign o_last        = r_out_last;

    // Setup arithmetic: saturate the grid, check both ends, pick the major axis
    always_comb begin
        w_eff = (r_grid_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_grid_width;
        h_eff = (r_grid_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_grid_height;
        ends_ok = in_range(r_x0, w_eff) && in_range(r_y0, h_eff) &&
                  in_range(r_x1, w_eff) && in_range(r_y1, h_eff);

        dx  = {r_x1[COORD_W-1], r_x1} - {r_x0[COORD_W-1], r_x0};
        dy  = {r_y1[COORD_W-1], r_y1} - {r_y0[COORD_W-1], r_y0};
        adx = dx[COORD_W] ? DELTA_W'(-dx) : DELTA_W'(dx);
        ady = dy[COORD_W] ? DELTA_W'(-dy) : DELTA_W'(dy);

        if (dx == '0)           sdx = '0;
        else if (dx[COORD_W])   sdx = -STEP_W'(1);
        else                    sdx = STEP_W'(1);

        if (dy == '0)           sdy = '0;
        else if (dy[COORD_W])   sdy = -$signed({1'b0, w_eff});
        else                    sdy = $signed({1'b0, w_eff});

        if (adx >= ady) begin
            line_c.major  = adx;
            line_c.minor  = ady;
            line_c.step_a = sdx;
            line_c.step_b = sdy;
        end else begin
            line_c.major  = ady;
            line_c.minor  = adx;
            line_c.step_a = sdy;
            line_c.step_b = sdx;
        end
        // free-walk step count max(major-1, 0)
        cnt_c = (line_c.major == '0) ? '0 : line_c.major - DELTA_W'(1);
    end

    // Offset unit, shared by start (setup) and end (next cycle): row * width + col.
    // Results are used only once both ends are known to be in the grid.
    always_comb begin
        mul_x   = (r_state == S_SETUP) ? r_x0 : r_x1;
        mul_y   = (r_state == S_SETUP) ? r_y0 : r_y1;
        mul_sum = (OFF_W+1)'(mul_y[DELTA_W-1:0]) * (OFF_W+1)'(w_eff) +
                  (OFF_W+1)'(mul_x[DELTA_W-1:0]);
        mul_off = mul_sum[OFF_W-1:0];
    end

    gdw_step u_step (
        .i_line (r_line),
        .i_cur  (r_walk),
        .o_nxt  (walk_nxt)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept_in) n_state = S_SETUP;
            S_SETUP:  n_state = ends_ok ? S_ENDOFF : S_IDLE;
            S_ENDOFF: n_state = S_WALK;
            S_WALK:   if (out_free && r_cnt == '0) n_state = S_LAST;
            S_LAST:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_grid_width  <= DIM_W'(MAX_DIM);
            r_grid_height <= DIM_W'(MAX_DIM);
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                    CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                    default: ;  // drop writes to unknown registers
                endcase
            end

            // output register: load on a walk or end word, else drain on ready
            if (out_free && (r_state == S_WALK || r_state == S_LAST))
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_x0 <= i_start_x;
            r_y0 <= i_start_y;
            r_x1 <= i_end_x;
            r_y1 <= i_end_y;
        end

        if (r_state == S_SETUP) begin
            r_line        <= line_c;
            r_cnt         <= cnt_c;
            r_walk.offset <= $signed({1'b0, mul_off});
            r_walk.err    <= {1'b0, line_c.major >> 1};
        end

        if (r_state == S_ENDOFF)
            r_end_off <= mul_off;

        // emit current cell free, then advance unless this was the last free cell
        if (r_state == S_WALK && out_free) begin
            r_out_off  <= r_walk.offset[OFF_W-1:0];
            r_out_mark <= 1'b0;
            r_out_last <= 1'b0;
            if (r_cnt != '0) begin
                r_walk <= walk_nxt;
                r_cnt  <= r_cnt - DELTA_W'(1);
            end
        end

        // end cell marked occupied, final word of the line
        if (r_state == S_LAST && out_free) begin
            r_out_off  <= r_end_off;
            r_out_mark <= 1'b1;
            r_out_last <= 1'b1;
        end
    end

endmodule

// ===== tb/grid_line_cell_walker_checker.sv =====
`timescale 1ns / 100ps
// Result checker for grid_line_cell_walker: predicts the cell words of every
// accepted line request and compares them with the result channel.
// Depends on gdw_pkg only; instantiated beside the block by the testbench top.
module grid_line_cell_walker_checker
    import gdw_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic signed [COORD_W-1:0] i_start_x,
    input  logic signed [COORD_W-1:0] i_start_y,
    input  logic signed [COORD_W-1:0] i_end_x,
    input  logic signed [COORD_W-1:0] i_end_y,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [OFF_W-1:0]          i_cell_offset,
    input  logic                      i_mark,
    input  logic                      i_last,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [DIM_W-1:0]          i_cfg_data,
    output int                        o_failures,
    output int                        o_pending,
    output int                        o_cells
);

    typedef struct {
        logic [OFF_W-1:0] offset;
        logic             mark;
        logic             last;
    } t_cell_word;

    t_cell_word       cell_q[$];
    logic [DIM_W-1:0] width_reg   = 7'd64;
    logic [DIM_W-1:0] height_reg  = 7'd64;
    int               fail_cnt    = 0;
    int               pending_cnt = 0;
    int               cells_cnt   = 0;

    assign o_failures = fail_cnt;
    assign o_pending  = pending_cnt;
    assign o_cells    = cells_cnt;

    // Registers above the largest grid saturate
    function automatic int clamp_dim(input logic [DIM_W-1:0] r);
        return (int'(r) > MAX_DIM) ? MAX_DIM : int'(r);
    endfunction

    function automatic void push_cell(input int off, input logic m, input logic l);
        t_cell_word c;
        c.offset = OFF_W'(off);
        c.mark   = m;
        c.last   = l;
        cell_q.push_back(c);
    endfunction

    // Bresenham walk on linear offsets; off-grid ends give nothing
    function automatic void walk_line(input int x0, input int y0, input int x1, input int y1);
        int w, h, dx, dy, adx, ady, sx, sy;
        int major, minor, step_a, step_b, err, off, i;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (x0 < 0 || x0 >= w || y0 < 0 || y0 >= h) return;
        if (x1 < 0 || x1 >= w || y1 < 0 || y1 >= h) return;
        dx  = x1 - x0;
        dy  = y1 - y0;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        sx  = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
        sy  = (dy > 0) ? w : ((dy < 0) ? -w : 0);
        if (adx >= ady) begin
            major = adx; minor = ady; step_a = sx; step_b = sy;
        end else begin
            major = ady; minor = adx; step_a = sy; step_b = sx;
        end
        err = major / 2;
        off = y0 * w + x0;
        push_cell(off, 1'b0, 1'b0);
        for (i = 0; i < major - 1; i++) begin
            off += step_a;
            err += minor;
            if (err >= major) begin
                off += step_b;
                err -= major;
            end
            push_cell(off, 1'b0, 1'b0);
        end
        push_cell(y1 * w + x1, 1'b1, 1'b1);
    endfunction

    always @(posedge i_clk) begin
        t_cell_word want;
        if (!i_rst_n) begin
            width_reg  = 7'd64;
            height_reg = 7'd64;
            cell_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                cells_cnt++;
                if (cell_q.size() == 0) begin
                    $error("unexpected cell word: cell_offset %0d mark %0d last %0d",
                           i_cell_offset, i_mark, i_last);
                    fail_cnt++;
                end else begin
                    want = cell_q.pop_front();
                    if (i_cell_offset !== want.offset) begin
                        $error("cell_offset mismatch: expected %0d, actual %0d",
                               want.offset, i_cell_offset);
                        fail_cnt++;
                    end
                    if (i_mark !== want.mark) begin
                        $error("mark mismatch: expected %0d, actual %0d", want.mark, i_mark);
                        fail_cnt++;
                    end
                    if (i_last !== want.last) begin
                        $error("last mismatch: expected %0d, actual %0d", want.last, i_last);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                walk_line(int'(i_start_x), int'(i_start_y), int'(i_end_x), int'(i_end_y));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_GRID_WIDTH)
                    width_reg = i_cfg_data;
                else if (i_cfg_index == CFG_GRID_HEIGHT)
                    height_reg = i_cfg_data;
            end
        end
        pending_cnt = cell_q.size();
    end

endmodule

// ===== tb/grid_line_cell_walker_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for grid_line_cell_walker: drives line requests, result
// back-pressure and grid register writes, and gives the verdict.
// Depends on gdw_pkg, the block and grid_line_cell_walker_checker.
module grid_line_cell_walker_tb;
    import gdw_pkg::*;

    localparam int LIMIT_CYCLES   = 1_500_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int TARGET_ITEMS   = 150;
    // Indexes the block does not decode; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      out_valid;
    logic                      out_ready;
    logic [OFF_W-1:0]          cell_offset;
    logic                      mark;
    logic                      last;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [DIM_W-1:0]          cfg_data;

    int failures;
    int pending;
    int cells;

    // Effective grid as the block should see it, for shaping the stimulus
    int w_eff      = 64;
    int h_eff      = 64;
    int n_sent     = 0;
    int n_on_grid  = 0;
    int n_settings = 0;
    int cycles     = 0;
    bit quiet      = 1'b0;

    grid_line_cell_walker i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_start_x     (start_x),
        .i_start_y     (start_y),
        .i_end_x       (end_x),
        .i_end_y       (end_y),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_cell_offset (cell_offset),
        .o_mark        (mark),
        .o_last        (last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    grid_line_cell_walker_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_start_x     (start_x),
        .i_start_y     (start_y),
        .i_end_x       (end_x),
        .i_end_y       (end_y),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_cell_offset (cell_offset),
        .i_mark        (mark),
        .i_last        (last),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_failures    (failures),
        .o_pending     (pending),
        .o_cells       (cells)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Guard against a hung handshake
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("grid_line_cell_walker_tb failed");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long; none in quiet phases
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // Grid register value: mostly a real grid, a few tiny, oversized or zero
    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return $urandom_range(65, 127);
        if (r < 10) return 0;
        if (r < 25) return $urandom_range(1, 4);
        return $urandom_range(1, 64);
    endfunction

    function automatic bit on_grid(input int x, input int y);
        return x >= 0 && x < w_eff && y >= 0 && y < h_eff;
    endfunction

    // Result side: hold ready low for a random gap, then high for a stretch
    initial begin
        int n;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Offer one line request and hold it until the word is taken.
    // Valid stays high on return; a gap or a drain drops it.
    task automatic send_line(input int sx, input int sy, input int ex, input int ey);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= COORD_W'(sx);
        start_y  <= COORD_W'(sy);
        end_x    <= COORD_W'(ex);
        end_y    <= COORD_W'(ey);
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        n_sent++;
        if (on_grid(sx, sy) && on_grid(ex, ey)) n_on_grid++;
    endtask

    // Drop valid and wait until every predicted cell word has come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // Write one register; the block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIM_W'(val);
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_GRID_WIDTH)
            w_eff = (val > MAX_DIM) ? MAX_DIM : val;
        else if (idx == CFG_GRID_HEIGHT)
            h_eff = (val > MAX_DIM) ? MAX_DIM : val;
    endtask

    // Drain, let an off-grid request finish, then set both registers
    task automatic set_grid(input int w, input int h);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
        n_settings++;
    endtask

    // Mostly well-formed lines with random ends, some with one end just off
    // the grid, the rest raw 8-bit noise
    task automatic random_line();
        int kind, sx, sy, ex, ey;
        kind = $urandom_range(0, 99);
        if (w_eff > 0 && h_eff > 0 && kind < 80) begin
            sx = $urandom_range(0, w_eff - 1);
            sy = $urandom_range(0, h_eff - 1);
            ex = $urandom_range(0, w_eff - 1);
            ey = $urandom_range(0, h_eff - 1);
            if (kind < 8) begin
                ex = sx;
                ey = sy;
            end else if (kind >= 70) begin
                case ($urandom_range(0, 3))
                    0:       sx = -1;
                    1:       ex = w_eff;
                    2:       sy = -1 - $urandom_range(0, 3);
                    default: ey = h_eff;
                endcase
            end
        end else begin
            sx = $urandom_range(0, 255);
            sy = $urandom_range(0, 255);
            ex = $urandom_range(0, 255);
            ey = $urandom_range(0, 255);
            sx -= 128;
            sy -= 128;
            ex -= 128;
            ey -= 128;
        end
        send_line(sx, sy, ex, ey);
    endtask

    initial begin
        int phase_len;
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        start_x   = '0;
        start_y   = '0;
        end_x     = '0;
        end_y     = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GRID_WIDTH;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset grid is 64 x 64: corners, diagonals, axes, same cell, off grid
        send_line(0, 0, 63, 63);
        send_line(63, 0, 0, 63);
        send_line(0, 0, 0, 0);
        send_line(63, 63, 63, 63);
        send_line(0, 5, 63, 7);
        send_line(5, 0, 7, 63);
        send_line(10, 10, 3, 40);
        send_line(0, 0, 63, 0);
        send_line(0, 63, 0, 0);
        send_line(-1, 0, 3, 3);
        send_line(0, 0, 64, 0);
        send_line(-128, 127, 127, -128);
        send_line(127, -128, -128, 127);

        // Oversized registers saturate to the largest grid
        set_grid(127, 127);
        send_line(0, 0, 63, 63);
        send_line(64, 0, 0, 0);

        // Undecoded indexes must leave the grid alone
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_SPARE_A, 5);
        write_reg(CFG_SPARE_B, 0);
        send_line(63, 63, 0, 0);

        // Zero width: nothing is on the grid
        set_grid(0, 64);
        send_line(0, 0, 0, 0);

        // Single cell grid, then a single row
        set_grid(1, 1);
        send_line(0, 0, 0, 0);
        send_line(0, 0, 1, 0);
        set_grid(64, 1);
        send_line(0, 0, 63, 0);
        send_line(63, 0, 1, 0);

        // Random phases, each with its own grid and idling style
        while (n_sent < TARGET_ITEMS) begin
            set_grid(pick_dim(), pick_dim());
            quiet = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(10, 25);
            repeat (phase_len) begin
                random_line();
                // Now and then hold the sender until the walk is fully out
                if ($urandom_range(0, 19) == 0) drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d line requests, %0d of them on the grid, %0d cell words",
                 n_sent, n_on_grid, cells);
        $display("across %0d grid settings including zero, one and oversized registers",
                 n_settings);
        if (failures == 0 && pending == 0) begin
            $display("grid_line_cell_walker_tb passed");
        end else begin
            $display("grid_line_cell_walker_tb failed");
        end
        $finish;
    end

endmodule
